>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame handler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CHK_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/i2csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csc_pkg
// Types and constants shared by the I2C checksum frame handler.
// ----------------------------------------------------------------------------
package i2csc_pkg;

    // Controller status event codes
    localparam logic [2:0] EV_READ_ADDR  = 3'd0;
    localparam logic [2:0] EV_BYTE_SENT  = 3'd1;
    localparam logic [2:0] EV_WRITE_ADDR = 3'd2;
    localparam logic [2:0] EV_BYTE_RX    = 3'd3;
    localparam logic [2:0] EV_STOP       = 3'd4;
    localparam logic [2:0] EV_UNEXPECTED = 3'd5;
    localparam logic [2:0] EV_SERVICE    = 3'd6;

    localparam int RX_FRAME_BYTES = 3;
    localparam int TX_FRAME_BYTES = 3;

    localparam int RX_CNT_W = $clog2(RX_FRAME_BYTES + 1);
    localparam int RX_IDX_W = $clog2(RX_FRAME_BYTES);
    localparam int TX_CNT_W = $clog2(TX_FRAME_BYTES + 1);
    localparam int TX_IDX_W = $clog2(TX_FRAME_BYTES);

    localparam logic [RX_CNT_W-1:0] RX_FULL = RX_CNT_W'(RX_FRAME_BYTES);
    localparam logic [TX_CNT_W-1:0] TX_FULL = TX_CNT_W'(TX_FRAME_BYTES);

    localparam logic [7:0] CS_BASE   = 8'hFF;
    localparam logic [7:0] IDLE_BYTE = 8'hFF;

    // Classified operation handed from front end to back end
    typedef enum logic [2:0] {
        OP_READ_ADDR,
        OP_BYTE_SENT,
        OP_WRITE_ADDR,
        OP_BYTE_RX,
        OP_STOP,
        OP_ERROR,
        OP_SERVICE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } q_entry_t;

endpackage

>>> design/i2csc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csc_front
// Accepts status events and classifies them into queue entries.
// ----------------------------------------------------------------------------
module i2csc_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         event_req,
    input  logic [7:0]         rx_byte,
    input  logic               q_full,
    output logic               push,
    output i2csc_pkg::q_entry_t push_entry
);
    import i2csc_pkg::*;

    op_t op;

    always_comb
    begin
        unique case (event_req)
            EV_READ_ADDR:  op = OP_READ_ADDR;
            EV_BYTE_SENT:  op = OP_BYTE_SENT;
            EV_WRITE_ADDR: op = OP_WRITE_ADDR;
            EV_BYTE_RX:    op = OP_BYTE_RX;
            EV_STOP:       op = OP_STOP;
            EV_SERVICE:    op = OP_SERVICE;
            // unexpected status and the unused code alike
            default:       op = OP_ERROR;
        endcase
    end

    assign in_ready        = !q_full;
    assign push            = in_valid && !q_full;
    assign push_entry.op   = op;
    // data only travels with a received byte
    assign push_entry.data = (op == OP_BYTE_RX) ? rx_byte : 8'h00;

endmodule

>>> design/i2csc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csc_queue
// Small FIFO decoupling the event front end from the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2csc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  i2csc_pkg::q_entry_t push_entry,
    input  logic                pop,
    output i2csc_pkg::q_entry_t head_entry,
    output logic                q_full,
    output logic                q_empty
);
    import i2csc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q_entry_t            entries [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry = entries[rd_ptr_reg];
    assign q_full     = (count_reg == CNT_FULL);
    assign q_empty    = (count_reg == '0);

    `CHK_IMPLY(a_q_no_overflow, clk, rst_n, push, count_reg != CNT_FULL, "push into full queue")
    `CHK_IMPLY(a_q_no_underflow, clk, rst_n, pop, count_reg != '0, "pop from empty queue")

endmodule

>>> design/i2csc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csc_back
// Executes queued operations on the frame state and registers the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2csc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  i2csc_pkg::q_entry_t head_entry,
    input  logic                q_empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          tx_byte,
    output logic                tx_valid,
    output logic [7:0]          mode_code,
    output logic [7:0]          temp_code,
    output logic                frame_accepted,
    output logic                bus_error
);
    import i2csc_pkg::*;

    // frame state
    logic [7:0]          rx_frame [RX_FRAME_BYTES];
    logic [7:0]          reply_frame_reg [TX_FRAME_BYTES];
    logic [7:0]          reply_frame_next [TX_FRAME_BYTES];
    logic [RX_CNT_W-1:0] rx_count_reg,    rx_count_next;
    logic                frame_ready_reg, frame_ready_next;
    logic [TX_CNT_W-1:0] tx_index_reg,    tx_index_next;
    logic [7:0]          mode_reg,        mode_next;
    logic [7:0]          temp_reg,        temp_next;
    logic                error_reg,       error_next;
    logic [7:0]          reply_code_reg;

    // result register
    logic                out_valid_reg,   out_valid_next;
    logic [7:0]          tx_byte_reg;
    logic                tx_valid_reg;
    logic [7:0]          mode_code_reg;
    logic [7:0]          temp_code_reg;
    logic                accepted_reg;
    logic                bus_error_reg;

    logic                rx_wr_en;
    logic [7:0]          txb;
    logic                txv;
    logic                acc;
    logic [7:0]          frame_cs;

    assign pop      = !q_empty && (!out_valid_reg || out_ready);
    assign frame_cs = CS_BASE - rx_frame[0] - rx_frame[1];

    always_comb
    begin
        rx_count_next    = rx_count_reg;
        frame_ready_next = frame_ready_reg;
        tx_index_next    = tx_index_reg;
        mode_next        = mode_reg;
        temp_next        = temp_reg;
        error_next       = error_reg;
        reply_frame_next = reply_frame_reg;
        rx_wr_en         = 1'b0;
        txb              = 8'h00;
        txv              = 1'b0;
        acc              = 1'b0;
        if (pop)
        begin
            unique case (head_entry.op)
                OP_READ_ADDR:
                begin
                    txv           = 1'b1;
                    txb           = reply_frame_reg[0];
                    tx_index_next = TX_CNT_W'(1);
                end
                OP_BYTE_SENT:
                begin
                    txv = 1'b1;
                    if (tx_index_reg < TX_FULL)
                    begin
                        txb           = reply_frame_reg[tx_index_reg[TX_IDX_W-1:0]];
                        tx_index_next = tx_index_reg + 1'b1;
                    end
                    else
                    begin
                        txb = IDLE_BYTE;  // reply exhausted, bus released
                    end
                end
                OP_WRITE_ADDR:
                begin
                    rx_count_next = '0;
                end
                OP_BYTE_RX:
                begin
                    // surplus bytes past a full frame are dropped
                    if (rx_count_reg < RX_FULL)
                    begin
                        rx_wr_en      = 1'b1;
                        rx_count_next = rx_count_reg + 1'b1;
                        if (rx_count_reg == RX_FULL - 1'b1)
                        begin
                            frame_ready_next = 1'b1;
                        end
                    end
                end
                OP_STOP:
                begin
                    rx_count_next = '0;
                    tx_index_next = '0;
                end
                OP_ERROR:
                begin
                    rx_count_next = '0;
                    tx_index_next = '0;
                    error_next    = 1'b1;
                end
                OP_SERVICE:
                begin
                    if (frame_ready_reg)
                    begin
                        frame_ready_next = 1'b0;
                        if (frame_cs == rx_frame[2])
                        begin
                            mode_next = rx_frame[0];
                            temp_next = rx_frame[1];
                            acc       = 1'b1;
                        end
                        // reply rebuilt whether or not the checksum held
                        reply_frame_next[0] = reply_code_reg;
                        reply_frame_next[1] = reply_code_reg;
                        reply_frame_next[2] = CS_BASE - {reply_code_reg[6:0], 1'b0};
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg    <= '0;
            frame_ready_reg <= 1'b0;
            tx_index_reg    <= '0;
            mode_reg        <= '0;
            temp_reg        <= '0;
            error_reg       <= 1'b0;
            reply_code_reg  <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < TX_FRAME_BYTES; i++)
            begin
                reply_frame_reg[i] <= '0;
            end
        end
        else
        begin
            rx_count_reg    <= rx_count_next;
            frame_ready_reg <= frame_ready_next;
            tx_index_reg    <= tx_index_next;
            mode_reg        <= mode_next;
            temp_reg        <= temp_next;
            error_reg       <= error_next;
            out_valid_reg   <= out_valid_next;
            reply_frame_reg <= reply_frame_next;
            if (cfg_wr_en)
            begin
                reply_code_reg <= cfg_wr_data;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (rx_wr_en)
        begin
            rx_frame[rx_count_reg[RX_IDX_W-1:0]] <= head_entry.data;
        end
        if (pop)
        begin
            tx_byte_reg   <= txb;
            tx_valid_reg  <= txv;
            mode_code_reg <= mode_next;
            temp_code_reg <= temp_next;
            accepted_reg  <= acc;
            bus_error_reg <= error_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tx_byte        = tx_byte_reg;
    assign tx_valid       = tx_valid_reg;
    assign mode_code      = mode_code_reg;
    assign temp_code      = temp_code_reg;
    assign frame_accepted = accepted_reg;
    assign bus_error      = bus_error_reg;

    `CHK_IMPLY(a_rx_count_range, clk, rst_n, 1'b1, rx_count_reg <= RX_FULL, "rx_count past frame")
    `CHK_IMPLY(a_tx_index_range, clk, rst_n, 1'b1, tx_index_reg <= TX_FULL, "tx_index past reply")
    `CHK_NEXT(a_service_consumes, clk, rst_n,
              pop && (head_entry.op == OP_SERVICE), !frame_ready_reg,
              "service left frame ready")

endmodule

>>> design/i2c_slave_checksum_frame_handler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_checksum_frame_handler
// Slave-side command/reply frame handler behind an I2C bus controller.
// ----------------------------------------------------------------------------
// Takes one controller status event per transaction and returns exactly one
// result transaction for each. Throughput is one event per clock while the
// result side keeps taking results; an accepted event is written into the
// event queue and its result then into the result register, later when the
// result side stalls. The rate is set by the back end, which updates the
// whole frame state per event. The input side keeps accepting while a result
// waits, until the QUEUE_DEPTH-entry queue fills.
// reply_code is written through cfg_wr_en/cfg_wr_data and is picked up by
// the next service of a full frame; write it only while the block is idle.
// ----------------------------------------------------------------------------
//
// Structure
//   front : decodes the event code into an operation (codes 5 and 7 both
//           map to the error operation) and pushes it into the queue.
//   queue : small FIFO, lets input and result sides stall independently.
//   back  : owns the frame state; assembles the 3-byte command frame,
//           checks 0xFF - (b0 + b1) == b2 on service, latches mode/temp on
//           a match, rebuilds the reply {code, code, 0xFF - 2*code} and
//           streams reply bytes on read events.
//
// Notes
//   - Received bytes past a full frame are dropped until the count is
//     cleared by addressing for write, stop or an error.
//   - The transmit index saturates; reading past the reply gives 0xFF.
//   - bus_error is sticky until reset.
// ----------------------------------------------------------------------------
module i2c_slave_checksum_frame_handler #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    // event channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  event_req,
    input  logic [7:0]  rx_byte,

    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic [7:0]  mode_code,
    output logic [7:0]  temp_code,
    output logic        frame_accepted,
    output logic        bus_error
);
    import i2csc_pkg::*;

    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;
    q_entry_t push_entry;
    q_entry_t head_entry;

    i2csc_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .event_req  (event_req),
        .rx_byte    (rx_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    i2csc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_full     (q_full),
        .q_empty    (q_empty)
    );

    i2csc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .head_entry     (head_entry),
        .q_empty        (q_empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tx_byte        (tx_byte),
        .tx_valid       (tx_valid),
        .mode_code      (mode_code),
        .temp_code      (temp_code),
        .frame_accepted (frame_accepted),
        .bus_error      (bus_error)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C slave checksum frame handler.
// ----------------------------------------------------------------------------
// Drives controller status events through the valid/ready event channel and
// checks every result transaction against an in-bench model of the frame
// state. The model covers frame assembly, the checksum test on service, the
// reply rebuild and the reply stream. Directed tests come first: reply
// readout at reset, good and bad checksums, surplus bytes, early re-address
// and the sticky bus error. A back-pressure test and randomised traffic
// phases follow. Both channels idle at random, and reply_code is rewritten
// between phases while the block is quiet.
// ----------------------------------------------------------------------------
module tb_top;
    import i2csc_pkg::*;

    // Code 7 has no name in the package; the block treats it as unexpected
    localparam logic [2:0] EV_RESERVED = 3'd7;

    localparam int IDLE_PCT      = 19;    // idle chance per cycle, both sides
    localparam int HOLD_CYCLES   = 64;    // long result-side hold-off
    localparam int STALL_LIMIT   = 1000;  // cycles with no transaction at all
    localparam int MAX_REPORTS   = 40;
    localparam int DRAIN_CYCLES  = 6;     // covers queue plus result register
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 180;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [7:0] mode_code;
        logic [7:0] temp_code;
        logic       frame_accepted;
        logic       bus_error;
    } handler_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] event_req;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] mode_code;
    logic [7:0] temp_code;
    logic       frame_accepted;
    logic       bus_error;

    i2c_slave_checksum_frame_handler uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .event_req      (event_req),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tx_byte        (tx_byte),
        .tx_valid       (tx_valid),
        .mode_code      (mode_code),
        .temp_code      (temp_code),
        .frame_accepted (frame_accepted),
        .bus_error      (bus_error)
    );

    // ------------------------------------------------------------------------
    // Frame state as the bench expects it (reset values)
    // ------------------------------------------------------------------------
    logic [7:0]          cmd_frame [RX_FRAME_BYTES] = '{default: 8'h00};
    logic [RX_CNT_W-1:0] cmd_fill    = '0;
    logic                cmd_ready   = 1'b0;
    logic [7:0]          reply_buf [TX_FRAME_BYTES] = '{default: 8'h00};
    logic [TX_CNT_W-1:0] reply_pos   = '0;
    logic [7:0]          mode_q      = 8'h00;
    logic [7:0]          temp_q      = 8'h00;
    logic                err_seen    = 1'b0;
    logic [7:0]          reply_code_q = 8'h00;

    handler_result_t expected_results [$];

    int fail_count   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int stall_cycles = 0;
    bit quiet        = 1'b0;   // no idling on either side while set
    bit stall_req    = 1'b0;   // asks the result side for a long hold-off

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Expected-result model
    // ------------------------------------------------------------------------

    // Next reply byte; the read pointer saturates and then gives the idle byte
    function automatic logic [7:0] next_reply_byte();
        logic [7:0] b;
        if (reply_pos < TX_FULL)
        begin
            b = reply_buf[reply_pos];
            reply_pos = reply_pos + 1'b1;
        end
        else
            b = IDLE_BYTE;
        return b;
    endfunction

    function automatic handler_result_t predict_event(input logic [2:0] ev,
                                                      input logic [7:0] data);
        handler_result_t r;
        logic [7:0]      sum_chk;
        r = '0;
        case (ev)
            EV_READ_ADDR:
            begin
                reply_pos  = '0;
                r.tx_byte  = next_reply_byte();
                r.tx_valid = 1'b1;
            end
            EV_BYTE_SENT:
            begin
                r.tx_byte  = next_reply_byte();
                r.tx_valid = 1'b1;
            end
            EV_WRITE_ADDR:
                cmd_fill = '0;   // ready mark is left alone
            EV_BYTE_RX:
            begin
                // bytes beyond a full frame are dropped
                if (cmd_fill < RX_FULL)
                begin
                    cmd_frame[cmd_fill] = data;
                    cmd_fill = cmd_fill + 1'b1;
                    if (cmd_fill == RX_FULL)
                        cmd_ready = 1'b1;
                end
            end
            EV_STOP:
            begin
                cmd_fill  = '0;
                reply_pos = '0;
            end
            EV_SERVICE:
            begin
                if (cmd_ready)
                begin
                    cmd_ready = 1'b0;
                    sum_chk = CS_BASE - cmd_frame[0] - cmd_frame[1];
                    if (sum_chk == cmd_frame[2])
                    begin
                        mode_q = cmd_frame[0];
                        temp_q = cmd_frame[1];
                        r.frame_accepted = 1'b1;
                    end
                    // reply is rebuilt whatever the checksum said
                    reply_buf[0] = reply_code_q;
                    reply_buf[1] = reply_code_q;
                    reply_buf[2] = CS_BASE - (reply_code_q << 1);
                end
            end
            default:
            begin
                // unexpected status and the reserved code
                cmd_fill  = '0;
                reply_pos = '0;
                err_seen  = 1'b1;
            end
        endcase
        r.mode_code = mode_q;
        r.temp_code = temp_q;
        r.bus_error = err_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] frame_check(input logic [7:0] b0, input logic [7:0] b1);
        return CS_BASE - b0 - b1;
    endfunction

    // One event transaction. Valid stays up, payload unchanged, until accepted.
    task automatic send_event(input logic [2:0] ev, input logic [7:0] data);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        event_req <= ev;
        rx_byte   <= data;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(predict_event(ev, data));
        items_sent++;
    endtask

    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2);
        send_event(EV_WRITE_ADDR, pick_byte());
        send_event(EV_BYTE_RX, b0);
        send_event(EV_BYTE_RX, b1);
        send_event(EV_BYTE_RX, b2);
    endtask

    // reply_code is only touched once every result is home
    task automatic set_reply_code(input logic [7:0] code);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        reply_code_q = code;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reply is all zeros after reset; reading past it gives the idle byte
    task automatic test_reply_at_reset();
        send_event(EV_READ_ADDR, 8'h00);
        send_event(EV_BYTE_SENT, 8'hFF);
        send_event(EV_BYTE_SENT, 8'h00);
        send_event(EV_BYTE_SENT, 8'hFF);
        send_event(EV_SERVICE, 8'h00);    // service with no frame waiting
    endtask

    task automatic test_frame_checksum();
        set_reply_code(8'hFF);
        send_frame(8'h00, 8'h00, 8'hFF);  // good frame, extremes of the bytes
        send_event(EV_SERVICE, 8'hFF);
        send_event(EV_READ_ADDR, 8'h00);
        send_event(EV_BYTE_SENT, 8'h00);
        send_frame(8'hFF, 8'hFF, 8'h00);  // sum wraps; checksum off by one
        send_event(EV_SERVICE, 8'h00);
    endtask

    task automatic test_frame_edge_cases();
        send_frame(8'h12, 8'h34, 8'hB9);
        send_event(EV_BYTE_RX, 8'h5A);    // surplus byte, dropped
        send_event(EV_WRITE_ADDR, 8'h00); // clears the count, frame stays ready
        send_event(EV_BYTE_RX, 8'h01);    // lands in byte 0 of the waiting frame
        send_event(EV_STOP, 8'h00);
        send_event(EV_SERVICE, 8'h00);
    endtask

    task automatic test_bus_error();
        send_event(EV_UNEXPECTED, 8'hA5);
        send_event(EV_RESERVED, 8'h5A);
    endtask

    // Result side holds off while events keep coming, so the input stalls
    task automatic test_back_pressure();
        int n;
        quiet     = 1'b1;
        stall_req = 1'b1;
        for (n = 0; n < 24; n++)
            send_event(3'($urandom), pick_byte());
        quiet = 1'b0;
    endtask

    // Mostly well-formed bus exchanges with random content, plus noise
    task automatic test_random_traffic();
        int         p;
        int         k;
        int         kind;
        int         target;
        logic [7:0] b0;
        logic [7:0] b1;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       set_reply_code(8'h00);
                1:       set_reply_code(8'hFF);
                default: set_reply_code(8'($urandom));
            endcase
            quiet  = (p == 2);   // one whole phase without idling
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                kind = $urandom_range(99);
                if (kind < 40)
                begin
                    b0 = pick_byte();
                    b1 = pick_byte();
                    send_frame(b0, b1,
                               ($urandom_range(3) != 0) ? frame_check(b0, b1) : pick_byte());
                    if ($urandom_range(7) == 0)
                        send_event(EV_BYTE_RX, pick_byte());
                    if ($urandom_range(4) != 0)
                        send_event(EV_STOP, pick_byte());
                end
                else if (kind < 60)
                    send_event(EV_SERVICE, pick_byte());
                else if (kind < 85)
                begin
                    send_event(EV_READ_ADDR, pick_byte());
                    for (k = $urandom_range(4); k > 0; k--)
                        send_event(EV_BYTE_SENT, pick_byte());
                    send_event(EV_STOP, pick_byte());
                end
                else if (kind < 93)
                begin
                    // truncated frame
                    send_event(EV_WRITE_ADDR, pick_byte());
                    for (k = $urandom_range(1, 2); k > 0; k--)
                        send_event(EV_BYTE_RX, pick_byte());
                    send_event(EV_STOP, pick_byte());
                end
                else
                    send_event(3'($urandom), pick_byte());
            end
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        in_valid    <= 1'b0;
        event_req   <= EV_STOP;
        rx_byte     <= 8'h00;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'h00;
        rst_n       <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reply_at_reset();
        test_frame_checksum();
        test_frame_edge_cases();
        test_bus_error();
        test_back_pressure();
        test_random_traffic();

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random ready, quiet stretches, and the long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (quiet)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Checking: each result transaction against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] result %0d: %s", $time, results_seen, what);
    endtask

    always @(posedge clk)
    begin : result_check
        handler_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no event outstanding");
            else
            begin
                want = expected_results.pop_front();
                if (tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte 0x%02h, expected 0x%02h",
                                              tx_byte, want.tx_byte));
                if (tx_valid !== want.tx_valid)
                    report_mismatch($sformatf("tx_valid %b, expected %b",
                                              tx_valid, want.tx_valid));
                if (mode_code !== want.mode_code)
                    report_mismatch($sformatf("mode_code 0x%02h, expected 0x%02h",
                                              mode_code, want.mode_code));
                if (temp_code !== want.temp_code)
                    report_mismatch($sformatf("temp_code 0x%02h, expected 0x%02h",
                                              temp_code, want.temp_code));
                if (frame_accepted !== want.frame_accepted)
                    report_mismatch($sformatf("frame_accepted %b, expected %b",
                                              frame_accepted, want.frame_accepted));
                if (bus_error !== want.bus_error)
                    report_mismatch($sformatf("bus_error %b, expected %b",
                                              bus_error, want.bus_error));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no transaction moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
